>>> hw/rtl/lzwc_pkg.sv
package lzwc_pkg;

  localparam int TABLE_SIZE_DEF    = 35023;
  localparam int MAX_CODE_BITS_DEF = 15;

  localparam int CFG_W = 9;

  localparam logic [CFG_W-1:0] END_CODE_RST   = 9'd256;
  localparam logic [CFG_W-1:0] BUMP_CODE_RST  = 9'd257;
  localparam logic [CFG_W-1:0] FLUSH_CODE_RST = 9'd258;
  localparam logic [CFG_W-1:0] FIRST_FREE_RST = 9'd259;

  localparam logic [4:0] START_WIDTH = 5'd9;
  localparam logic [7:0] MASK_RST    = 8'h80;

  // register indexes on the configuration port
  localparam logic [1:0] REG_END_CODE   = 2'd0;
  localparam logic [1:0] REG_BUMP_CODE  = 2'd1;
  localparam logic [1:0] REG_FLUSH_CODE = 2'd2;
  localparam logic [1:0] REG_FIRST_FREE = 2'd3;

endpackage

>>> hw/rtl/lzw_compressor_variable_width.sv
// channel   signals                               beat taken when
// input     in_valid in_stall data_byte last      in_valid && !in_stall
// output    out_valid out_stall packed_byte       out_valid && !out_stall
//           final_res
// config    cfg_write cfg_index cfg_data          cfg_write
//
// a byte after the first of its stream goes through hash reduction, then a read
// and a compare per dictionary probe; the dictionary memory has one write and one
// read port. the bit packer handles one bit a cycle while out_stall does not hold
// it. after reset, a flush and every end of stream a clearing pass over all
// TABLE_SIZE slots runs with in_stall high. reset is synchronous and active high.
// a full output register with out_stall high holds the packer on a byte boundary.
module lzw_compressor_variable_width #(
  parameter int TABLE_SIZE    = lzwc_pkg::TABLE_SIZE_DEF,
  parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] packed_byte,
  output logic       final_res,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [lzwc_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = MAX_CODE_BITS;
  localparam int IW = $clog2(TABLE_SIZE);
  localparam int NW = $clog2(TABLE_SIZE + 1);
  localparam int TW = IW + CW;
  localparam int SW = $clog2(CW);
  localparam logic [2:0] K_START = 3'(MAX_CODE_BITS - 9);

  typedef struct packed {
    logic          used;
    logic [CW-1:0] code;
    logic [CW-1:0] prefix;
    logic [7:0]    ch;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_READ, S_CMP, S_EMIT, S_TAIL, S_PART, S_CLEAR
  } state_t;

  typedef enum logic [2:0] {
    J_MISS, J_FLUSH, J_BUMP, J_LPFX, J_END
  } job_t;

  state_t state;
  job_t   job;

  logic [lzwc_pkg::CFG_W-1:0] end_code, bump_code, flush_code, first_free_code;

  logic [CW-1:0] prefix_code;
  logic          have_prefix;
  logic [CW:0]   next_free;
  logic [4:0]    code_width;
  logic [CW-1:0] bump_limit;
  logic [7:0]    bit_rack;
  logic [7:0]    bit_mask;

  logic [7:0]    ch_r;
  logic          last_r;
  logic [CW-1:0] hash_r;
  logic [2:0]    k;
  logic [IW-1:0] idx;
  logic [IW:0]   step_r;
  logic [NW-1:0] n_probe;
  logic [IW-1:0] clr_addr;
  logic          do_flush, do_bump, need_clear;
  logic [CW-1:0] code_reg;
  logic [4:0]    bits;

  entry_t mem [TABLE_SIZE];
  entry_t rd;
  logic   mem_we;
  logic [IW-1:0] mem_addr;
  entry_t mem_wdata;

  // hash reduction by shifted table size
  logic [TW-1:0] tsk;
  logic [CW-1:0] hash_red;
  // probe stepping, stride fixed by the first slot of the search
  logic [IW:0]   step;
  logic [IW:0]   idx_next;
  logic          hit, free_slot, exhausted;
  logic [CW:0]   nf_inc;
  logic [4:0]    sel;
  logic          cur_bit, completing, out_free, out_load;

  always_comb begin
    tsk      = TW'(TABLE_SIZE) << k;
    hash_red = ({{(TW-CW){1'b0}}, hash_r} >= tsk) ? hash_r - tsk[CW-1:0] : hash_r;

    step     = (IW'(hash_red) == '0) ? (IW+1)'(1)
                                     : (IW+1)'(TABLE_SIZE) - {1'b0, IW'(hash_red)};
    idx_next = ({1'b0, idx} >= step_r) ? {1'b0, idx} - step_r
                                       : {1'b0, idx} + ((IW+1)'(TABLE_SIZE) - step_r);

    free_slot = !rd.used;
    hit       = rd.used && (rd.prefix == prefix_code) && (rd.ch == ch_r);
    exhausted = (n_probe == NW'(TABLE_SIZE - 1));
    nf_inc    = next_free + 1'b1;

    sel        = bits - 5'd1;
    cur_bit    = code_reg[sel[SW-1:0]];
    completing = bit_mask[0];
    out_free   = !out_valid || !out_stall;
    out_load   = out_free && (((state == S_EMIT) && completing) || (state == S_PART));

    mem_we    = (state == S_CLEAR) || ((state == S_CMP) && free_slot);
    mem_addr  = (state == S_CLEAR) ? clr_addr : idx;
    mem_wdata = (state == S_CLEAR) ? '0
              : '{used: 1'b1, code: next_free[CW-1:0], prefix: prefix_code, ch: ch_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd <= mem[idx];
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      job             <= J_MISS;
      clr_addr        <= '0;
      end_code        <= lzwc_pkg::END_CODE_RST;
      bump_code       <= lzwc_pkg::BUMP_CODE_RST;
      flush_code      <= lzwc_pkg::FLUSH_CODE_RST;
      first_free_code <= lzwc_pkg::FIRST_FREE_RST;
      prefix_code     <= '0;
      have_prefix     <= 1'b0;
      next_free       <= (CW+1)'(lzwc_pkg::FIRST_FREE_RST);
      code_width      <= lzwc_pkg::START_WIDTH;
      bump_limit      <= CW'(511);
      bit_rack        <= '0;
      bit_mask        <= lzwc_pkg::MASK_RST;
      out_valid       <= 1'b0;
      need_clear      <= 1'b0;
      do_flush        <= 1'b0;
      do_bump         <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        unique case (cfg_index)
          lzwc_pkg::REG_END_CODE:   end_code        <= cfg_data;
          lzwc_pkg::REG_BUMP_CODE:  bump_code       <= cfg_data;
          lzwc_pkg::REG_FLUSH_CODE: flush_code      <= cfg_data;
          lzwc_pkg::REG_FIRST_FREE: first_free_code <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch_r       <= data_byte;
            last_r     <= last;
            need_clear <= 1'b0;
            if (!have_prefix) begin
              prefix_code <= CW'(data_byte);
              have_prefix <= 1'b1;
              state       <= S_TAIL;
            end else begin
              hash_r  <= {data_byte, {(CW-8){1'b0}}} ^ prefix_code;
              k       <= K_START;
              n_probe <= '0;
              state   <= S_HASH;
            end
          end
        end

        S_HASH: begin
          hash_r <= hash_red;
          if (k == 3'd0) begin
            idx    <= IW'(hash_red);
            step_r <= step;
            state  <= S_READ;
          end else begin
            k <= k - 3'd1;
          end
        end

        S_READ: begin
          state <= S_CMP;
        end

        S_CMP: begin
          priority if (hit) begin
            prefix_code <= rd.code;
            state       <= S_TAIL;
          end else if (free_slot || exhausted) begin
            // miss: the entry is written by the memory port when the slot is free
            next_free   <= nf_inc;
            do_flush    <= nf_inc[CW];
            do_bump     <= !nf_inc[CW] && (nf_inc[CW-1:0] > bump_limit);
            code_reg    <= prefix_code;
            bits        <= code_width;
            prefix_code <= CW'(ch_r);
            job         <= J_MISS;
            state       <= S_EMIT;
          end else begin
            n_probe <= n_probe + 1'b1;
            idx     <= idx_next[IW-1:0];
            state   <= S_READ;
          end
        end

        S_EMIT: begin
          if (!completing || out_free) begin
            if (completing) begin
              packed_byte <= bit_rack | (cur_bit ? bit_mask : 8'h00);
              final_res   <= (job == J_END) && (bits == 5'd1);
              out_valid   <= 1'b1;
              bit_rack    <= '0;
              bit_mask    <= lzwc_pkg::MASK_RST;
            end else begin
              bit_rack <= bit_rack | (cur_bit ? bit_mask : 8'h00);
              bit_mask <= bit_mask >> 1;
            end
            if (bits == 5'd1) begin
              unique case (job)
                J_MISS: begin
                  priority if (do_flush) begin
                    code_reg <= CW'(flush_code);
                    bits     <= code_width;
                    job      <= J_FLUSH;
                  end else if (do_bump) begin
                    code_reg <= CW'(bump_code);
                    bits     <= code_width;
                    job      <= J_BUMP;
                  end else begin
                    state <= S_TAIL;
                  end
                end
                J_FLUSH: begin
                  next_free  <= (CW+1)'(first_free_code);
                  code_width <= lzwc_pkg::START_WIDTH;
                  bump_limit <= CW'(511);
                  need_clear <= 1'b1;
                  state      <= S_TAIL;
                end
                J_BUMP: begin
                  code_width <= code_width + 5'd1;
                  bump_limit <= {bump_limit[CW-2:0], 1'b1};
                  state      <= S_TAIL;
                end
                J_LPFX: begin
                  code_reg <= CW'(end_code);
                  bits     <= code_width;
                  job      <= J_END;
                end
                J_END: begin
                  // stream over: back to a fresh dictionary and packer
                  next_free   <= (CW+1)'(first_free_code);
                  code_width  <= lzwc_pkg::START_WIDTH;
                  bump_limit  <= CW'(511);
                  prefix_code <= '0;
                  have_prefix <= 1'b0;
                  clr_addr    <= '0;
                  state       <= completing ? S_CLEAR : S_PART;
                end
                default: state <= S_TAIL;
              endcase
            end else begin
              bits <= bits - 5'd1;
            end
          end
        end

        S_TAIL: begin
          priority if (last_r) begin
            code_reg <= prefix_code;
            bits     <= code_width;
            job      <= J_LPFX;
            state    <= S_EMIT;
          end else if (need_clear) begin
            clr_addr <= '0;
            state    <= S_CLEAR;
          end else begin
            state <= S_IDLE;
          end
        end

        S_PART: begin
          if (out_free) begin
            packed_byte <= bit_rack;
            final_res   <= 1'b1;
            out_valid   <= 1'b1;
            bit_rack    <= '0;
            bit_mask    <= lzwc_pkg::MASK_RST;
            state       <= S_CLEAR;
          end
        end

        S_CLEAR: begin
          if (clr_addr == IW'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_READ)
    else $error("compare without a memory read");

  a_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(bit_mask))
    else $error("bit mask lost its single bit");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    code_width >= lzwc_pkg::START_WIDTH && code_width <= 5'(CW))
    else $error("code width out of range");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("input beat taken but sequencer idle");

endmodule

>>> tb/sv/lzw_compressor_variable_width_test.sv
`timescale 1ns / 100ps

module lzw_compressor_variable_width_test;

  localparam int unsigned DICT_SLOTS = lzwc_pkg::TABLE_SIZE_DEF;
  localparam int unsigned TOP_CODE   = (1 << lzwc_pkg::MAX_CODE_BITS_DEF) - 1;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } packed_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = '0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] packed_byte;
  logic       final_res;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = lzwc_pkg::REG_END_CODE;
  logic [lzwc_pkg::CFG_W-1:0] cfg_data = '0;

  lzw_compressor_variable_width u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .packed_byte(packed_byte),
    .final_res(final_res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the compressor
  logic [lzwc_pkg::CFG_W-1:0] end_val, bump_val, flush_val, first_free_val;
  bit          slot_used  [DICT_SLOTS];
  logic [15:0] slot_code  [DICT_SLOTS];
  logic [15:0] slot_prefix[DICT_SLOTS];
  logic [7:0]  slot_char  [DICT_SLOTS];
  logic [15:0] cur_prefix;
  bit          prefix_valid;
  logic [16:0] free_code;
  int unsigned width_now;
  logic [15:0] width_limit;
  logic [7:0]  rack;
  logic [7:0]  rack_mask;

  packed_beat_t code_bytes_q[$];
  int errors = 0;
  int bytes_in = 0;
  int bytes_out = 0;
  int streams_done = 0;
  bit quiet = 1'b0;
  int hold_left = 0;

  function automatic void clear_dict();
    slot_used   = '{default: 1'b0};
    free_code   = 17'(first_free_val);
    width_now   = lzwc_pkg::START_WIDTH;
    width_limit = 16'd511;
  endfunction

  function automatic void clear_stream();
    clear_dict();
    cur_prefix   = '0;
    prefix_valid = 1'b0;
    rack         = '0;
    rack_mask    = lzwc_pkg::MASK_RST;
  endfunction

  function automatic void pack_code(int unsigned code);
    int unsigned w;
    w = width_now;
    while (w > 0) begin
      w--;
      if ((code >> w) & 1) rack |= rack_mask;
      rack_mask >>= 1;
      if (rack_mask == 0) begin
        code_bytes_q.push_back('{code_byte: rack, stream_end: 1'b0});
        rack      = '0;
        rack_mask = lzwc_pkg::MASK_RST;
      end
    end
  endfunction

  function automatic void compress_byte(logic [7:0] ch, logic fin);
    int unsigned idx, stride, n, depth_before;
    bit hit, usable;
    depth_before = code_bytes_q.size();
    if (!prefix_valid) begin
      cur_prefix   = ch;
      prefix_valid = 1'b1;
    end else begin
      idx    = ((int'(ch) << (lzwc_pkg::MAX_CODE_BITS_DEF - 8)) ^ cur_prefix) % DICT_SLOTS;
      stride = (idx == 0) ? 1 : DICT_SLOTS - idx;
      hit    = 1'b0;
      usable = 1'b0;
      for (n = 0; n < DICT_SLOTS; n++) begin
        if (!slot_used[idx]) begin
          usable = 1'b1;
          break;
        end
        if (slot_prefix[idx] == cur_prefix && slot_char[idx] == ch) begin
          hit    = 1'b1;
          usable = 1'b1;
          break;
        end
        if (idx >= stride) idx -= stride;
        else idx += DICT_SLOTS - stride;
      end
      if (hit) begin
        cur_prefix = slot_code[idx];
      end else begin
        if (usable) begin
          slot_used[idx]   = 1'b1;
          slot_code[idx]   = free_code[15:0];
          slot_prefix[idx] = cur_prefix;
          slot_char[idx]   = ch;
        end
        free_code = free_code + 17'd1;
        pack_code(cur_prefix);
        cur_prefix = ch;
        if (free_code > TOP_CODE) begin
          pack_code(flush_val);
          clear_dict();
        end else if (free_code > width_limit) begin
          pack_code(bump_val);
          width_now++;
          width_limit = (width_limit << 1) | 16'd1;
        end
      end
    end
    if (fin) begin
      pack_code(cur_prefix);
      pack_code(end_val);
      if (rack_mask != lzwc_pkg::MASK_RST)
        code_bytes_q.push_back('{code_byte: rack, stream_end: 1'b0});
      if (code_bytes_q.size() > depth_before)
        code_bytes_q[code_bytes_q.size() - 1].stream_end = 1'b1;
      clear_stream();
    end
  endfunction

  // sender: leaves valid high on return unless it idled
  task automatic send_byte(logic [7:0] b, logic fin);
    in_valid  <= 1'b1;
    data_byte <= b;
    last      <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compress_byte(b, fin);
    bytes_in++;
    if (fin) streams_done++;
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (code_bytes_q.size() != 0) @(posedge clk);
  endtask

  // block idle: nothing owed, latency passed, clearing pass over
  task automatic write_reg(logic [1:0] idx, logic [lzwc_pkg::CFG_W-1:0] val);
    drain();
    repeat (64) @(posedge clk);
    while (in_stall) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      lzwc_pkg::REG_END_CODE:   end_val = val;
      lzwc_pkg::REG_BUMP_CODE:  bump_val = val;
      lzwc_pkg::REG_FLUSH_CODE: flush_val = val;
      default:                  first_free_val = val;
    endcase
  endtask

  task automatic set_codes(logic [lzwc_pkg::CFG_W-1:0] e, logic [lzwc_pkg::CFG_W-1:0] b,
                           logic [lzwc_pkg::CFG_W-1:0] f, logic [lzwc_pkg::CFG_W-1:0] ff);
    write_reg(lzwc_pkg::REG_END_CODE, e);
    write_reg(lzwc_pkg::REG_BUMP_CODE, b);
    write_reg(lzwc_pkg::REG_FLUSH_CODE, f);
    write_reg(lzwc_pkg::REG_FIRST_FREE, ff);
  endtask

  // alphabet 0 means any byte; small alphabets give dictionary hits
  task automatic send_stream(int len, int alphabet);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (alphabet == 0) ? 8'($urandom) : 8'($urandom_range(alphabet - 1) + 8'h61);
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic test_default_streams();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h41, 1'b0);
    repeat (5) send_byte(8'h41, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);
  endtask

  task automatic test_register_extremes();
    // width grows at the second stream's first new entry
    set_codes(9'd511, 9'd0, 9'd511, 9'd511);
    send_stream(12, 0);
    set_codes(9'd0, 9'd511, 9'd0, 9'd0);
    send_stream(12, 3);
  endtask

  task automatic test_backpressure();
    set_codes(lzwc_pkg::END_CODE_RST, lzwc_pkg::BUMP_CODE_RST,
              lzwc_pkg::FLUSH_CODE_RST, 9'd495);
    drain();
    hold_left = 600;
    send_stream(15, 0);
    hold_left = 0;
    for (int i = 0; i < 10; i++) send_byte(8'($urandom), 1'b0);
    // pause mid-stream until everything owed has come out
    drain();
    send_stream(10, 4);
  endtask

  task automatic test_random_streams();
    for (int s = 0; s < 5; s++) begin
      quiet = (s == 2);
      send_stream($urandom_range(40, 60), (s % 2) ? 0 : $urandom_range(2, 8));
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    packed_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      bytes_out++;
      if (code_bytes_q.size() == 0) begin
        $error("unexpected beat packed_byte=%h final_res=%b", packed_byte, final_res);
        errors++;
      end else begin
        want = code_bytes_q.pop_front();
        if (packed_byte !== want.code_byte) begin
          $error("packed_byte: expected %h, got %h", want.code_byte, packed_byte);
          errors++;
        end
        if (final_res !== want.stream_end) begin
          $error("final_res: expected %b, got %b", want.stream_end, final_res);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[lzw_compressor_variable_width] ERROR");
    $finish;
  end

  initial begin
    end_val        = lzwc_pkg::END_CODE_RST;
    bump_val       = lzwc_pkg::BUMP_CODE_RST;
    flush_val      = lzwc_pkg::FLUSH_CODE_RST;
    first_free_val = lzwc_pkg::FIRST_FREE_RST;
    clear_stream();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_streams();
    test_register_extremes();
    test_backpressure();
    test_random_streams();
    drain();
    repeat (200) @(posedge clk);
    if (code_bytes_q.size() != 0) begin
      $error("%0d packed bytes never arrived", code_bytes_q.size());
      errors++;
    end
    $display("covered %0d input bytes in %0d streams, %0d packed bytes out",
             bytes_in, streams_done, bytes_out);
    $display("register extremes, width bumps, dictionary hits, long output hold-off");
    if (errors == 0) $display("[lzw_compressor_variable_width] OK");
    else $display("[lzw_compressor_variable_width] ERROR");
    $finish;
  end

endmodule
